// File: rtl/efp_pkg.sv
// Shared types, constants and codes for the escape-time fractal pixel engine.
package efp_pkg;

    localparam int COORD_W = 16;
    localparam int CNT_W   = 11;
    localparam int COLOUR_W = 8;
    localparam int Z_W     = 18;
    localparam int P_W     = 2 * Z_W;
    localparam int MAG_W   = P_W + 1;

    localparam int unsigned FRAC_RE = 13;
    localparam int unsigned FRAC_IM = 12;

    localparam logic [MAG_W-1:0] ESCAPE_BOUND = MAG_W'(64'd4 << 26);

    localparam int MAX_ITERATIONS_DEF = 2000;
    localparam int PALETTE_STEPS_DEF  = 20;
    localparam int LIMIT_RESET        = 40;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_CONST_C    = 1'b1;

    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LIMIT    = 2'd0,
        CFG_JULIA_RE = 2'd1,
        CFG_JULIA_IM = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic                       mode;
        logic signed [COORD_W-1:0]  point_re;
        logic signed [COORD_W-1:0]  point_im;
    } t_pixel_in;

    typedef struct packed {
        logic [CNT_W-1:0]    iteration_count;
        logic                escaped;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] blue;
    } t_pixel_out;

    typedef struct packed {
        logic [CNT_W-1:0]           limit;
        logic signed [COORD_W-1:0]  julia_re;
        logic signed [COORD_W-1:0]  julia_im;
    } t_cfg;

    typedef struct packed {
        logic signed [Z_W-1:0] z_re;
        logic signed [Z_W-1:0] z_im;
        logic signed [Z_W-1:0] c_re;
        logic signed [Z_W-1:0] c_im;
        logic [CNT_W-1:0]      limit;
    } t_job;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_ITER,
        ENG_DIV,
        ENG_DONE
    } t_eng_state;

endpackage

// File: rtl/escape_time_fractal_pixel.sv
// Top level of the escape-time fractal pixel engine: configuration registers and the three parts.
//
// Each input transfer carries one point in Q13 fixed point and a mode bit: Mandelbrot mode starts
// z at zero with the point as c, Julia mode starts z at the point with the configured constant as
// c. The engine iterates z = z^2 + c, flooring the products by 2^13 and 2^12, until the squared
// magnitude reaches 4 << 26 or the count reaches the iteration limit (clamped to MAX_ITERATIONS).
// Each point yields one output transfer with the count, an escaped flag and red and blue palette
// bytes, which are black when the limit is reached. For each point the engine takes the job from
// the queue, iterates, runs the reciprocal multiplication that divides the red value by three,
// and then loads the output register, waiting there while the previous result is not yet taken.
// The iteration loop is one cycle per step because the three 18 by 18 bit
// products of z feed both the escape compare and the update in the same cycle. The front stage
// and a two-entry queue sit ahead of the engine, so new points are taken while the engine works
// and a finished result waits in its own register. The configuration port is always ready and
// should only be written while no point is in flight.
module escape_time_fractal_pixel #(
    parameter int MAX_ITERATIONS = efp_pkg::MAX_ITERATIONS_DEF,
    parameter int PALETTE_STEPS  = efp_pkg::PALETTE_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  efp_pkg::t_pixel_in                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output efp_pkg::t_pixel_out                 o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [efp_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [efp_pkg::COORD_W-1:0]         i_cfg_data
);

    efp_pkg::t_cfg r_cfg;
    efp_pkg::t_cfg n_cfg;

    logic          w_front_valid;
    logic          w_queue_full;
    efp_pkg::t_job w_front_job;
    logic          w_queue_valid;
    logic          w_queue_pop;
    efp_pkg::t_job w_queue_job;
    logic [$clog2(efp_pkg::QUEUE_DEPTH+1)-1:0] w_queue_count;

    assign o_cfg_ready = 1'b1;

    // Register writes; an index outside the list is dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            case (efp_pkg::t_cfg_index'(i_cfg_index))
                efp_pkg::CFG_LIMIT: begin
                    n_cfg.limit = i_cfg_data[efp_pkg::CNT_W-1:0];
                end
                efp_pkg::CFG_JULIA_RE: begin
                    n_cfg.julia_re = i_cfg_data;
                end
                efp_pkg::CFG_JULIA_IM: begin
                    n_cfg.julia_im = i_cfg_data;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.limit    <= efp_pkg::CNT_W'(efp_pkg::LIMIT_RESET);
            r_cfg.julia_re <= '0;
            r_cfg.julia_im <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // The front stage classifies each point against the current configuration.
    efp_front #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_front_valid),
        .i_ready (!w_queue_full),
        .o_job   (w_front_job)
    );

    // The queue lets the front keep taking points while the engine iterates.
    efp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_data  (w_front_job),
        .o_full  (w_queue_full),
        .o_valid (w_queue_valid),
        .i_pop   (w_queue_pop),
        .o_data  (w_queue_job),
        .o_count (w_queue_count)
    );

    // The engine runs one job at a time and owns the output register.
    efp_engine #(
        .MAX_ITERATIONS (MAX_ITERATIONS),
        .PALETTE_STEPS  (PALETTE_STEPS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_queue_valid),
        .o_job_pop   (w_queue_pop),
        .i_job       (w_queue_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // A point that reached the limit must come out black.
    a_black_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.escaped) |->
            (o_out_data.red == '0 && o_out_data.blue == '0))
        else $error("limit result is not black");

    // The queue never holds more jobs than it has room for.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queue_count <= ($clog2(efp_pkg::QUEUE_DEPTH+1))'(efp_pkg::QUEUE_DEPTH))
        else $error("queue occupancy out of range");

    // An accepted point is held by the front stage in the following cycle.
    a_front_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_front_valid)
        else $error("accepted point lost by the front stage");

    // The engine only takes a job that the queue actually offers.
    a_pop_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_queue_pop |-> w_queue_valid)
        else $error("engine popped an empty queue");

endmodule

// File: rtl/efp_front.sv
// Front stage: accepts a pixel, picks the start value and constant, and clamps the limit.
module efp_front #(
    parameter int MAX_ITERATIONS = efp_pkg::MAX_ITERATIONS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  efp_pkg::t_cfg     i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  efp_pkg::t_pixel_in i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output efp_pkg::t_job     o_job
);

    logic          r_valid;
    logic          n_valid;
    efp_pkg::t_job r_job;
    efp_pkg::t_job n_job;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_comb begin
        n_valid = r_valid;
        n_job   = r_job;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
            if (i_data.mode == efp_pkg::MODE_CONST_C) begin
                n_job.z_re = efp_pkg::Z_W'(i_data.point_re);
                n_job.z_im = efp_pkg::Z_W'(i_data.point_im);
                n_job.c_re = efp_pkg::Z_W'(i_cfg.julia_re);
                n_job.c_im = efp_pkg::Z_W'(i_cfg.julia_im);
            end else begin
                n_job.z_re = '0;
                n_job.z_im = '0;
                n_job.c_re = efp_pkg::Z_W'(i_data.point_re);
                n_job.c_im = efp_pkg::Z_W'(i_data.point_im);
            end
            if (int'(i_cfg.limit) > MAX_ITERATIONS) begin
                n_job.limit = efp_pkg::CNT_W'(MAX_ITERATIONS);
            end else begin
                n_job.limit = i_cfg.limit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

endmodule

// File: rtl/efp_queue.sv
// Short first-in first-out queue of classified jobs between the front and the engine.
module efp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  efp_pkg::t_job i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output efp_pkg::t_job o_data,
    output logic [$clog2(efp_pkg::QUEUE_DEPTH+1)-1:0] o_count
);

    localparam int DEPTH = efp_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    efp_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: rtl/efp_engine.sv
// Iteration engine: runs z = z^2 + c one step a cycle, then forms the palette and holds the result.
module efp_engine #(
    parameter int MAX_ITERATIONS = efp_pkg::MAX_ITERATIONS_DEF,
    parameter int PALETTE_STEPS  = efp_pkg::PALETTE_STEPS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    output logic                o_job_pop,
    input  efp_pkg::t_job       i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output efp_pkg::t_pixel_out o_out_data
);

    localparam int Z_W      = efp_pkg::Z_W;
    localparam int P_W      = efp_pkg::P_W;
    localparam int MAG_W    = efp_pkg::MAG_W;
    localparam int CNT_W    = efp_pkg::CNT_W;
    localparam int COLOUR_W = efp_pkg::COLOUR_W;

    // Largest count the limit register can reach after clamping.
    localparam int EFF_MAX  = (MAX_ITERATIONS < (2**CNT_W - 1)) ? MAX_ITERATIONS
                                                                 : (2**CNT_W - 1);
    localparam int Q_MAX    = (EFF_MAX * 256) / PALETTE_STEPS;
    localparam int Q_W_RAW  = $clog2(Q_MAX + 1);
    localparam int Q_W      = (Q_W_RAW < 10) ? 10 : Q_W_RAW;
    localparam int Q_STEP   = 256 / PALETTE_STEPS;
    localparam int R_STEP   = 256 % PALETTE_STEPS;
    localparam int REM_W    = $clog2(PALETTE_STEPS + 1);
    localparam int RSUM_W   = REM_W + 1;
    // Division by three as a multiplication by a rounded-up reciprocal.
    localparam int PM_W     = Q_W + 1;
    localparam int DIV_K    = PM_W + 1;
    localparam int PROD_W   = PM_W + DIV_K;
    localparam logic [PROD_W-1:0] DIV_M = PROD_W'((2**DIV_K) / 3 + 1);

    efp_pkg::t_eng_state r_state;
    efp_pkg::t_eng_state n_state;

    logic signed [Z_W-1:0] r_a, n_a;
    logic signed [Z_W-1:0] r_b, n_b;
    logic signed [Z_W-1:0] r_cr, n_cr;
    logic signed [Z_W-1:0] r_ci, n_ci;
    logic [CNT_W-1:0]      r_limit, n_limit;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [Q_W-1:0]        r_q, n_q;
    logic [REM_W-1:0]      r_rem, n_rem;
    logic                  r_esc, n_esc;
    logic                  r_neg, n_neg;
    logic [PM_W-1:0]       r_mag, n_mag;
    logic [COLOUR_W-1:0]   r_blue, n_blue;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic                  r_out_valid, n_out_valid;
    efp_pkg::t_pixel_out   r_out, n_out;

    logic signed [P_W-1:0] w_aa;
    logic signed [P_W-1:0] w_bb;
    logic signed [P_W-1:0] w_ab;
    logic [MAG_W-1:0]      w_mag;
    logic signed [P_W-1:0] w_re_sum;
    logic signed [P_W-1:0] w_im_sum;
    logic                  w_at_limit;
    logic [RSUM_W-1:0]     w_rem_sum;
    logic [Q_W-1:0]        w_q_diff;
    logic [Q_W-1:0]        w_blue_diff;
    logic [PM_W-1:0]       w_quot;
    logic [PM_W-1:0]       w_red_full;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        w_aa = r_a * r_a;
        w_bb = r_b * r_b;
        w_ab = r_a * r_b;
        w_mag = {1'b0, w_aa} + {1'b0, w_bb};
        w_re_sum = (w_aa >>> efp_pkg::FRAC_RE) - (w_bb >>> efp_pkg::FRAC_RE) + P_W'(r_cr);
        w_im_sum = (w_ab >>> efp_pkg::FRAC_IM) + P_W'(r_ci);
        w_at_limit = (r_count >= r_limit);
        w_rem_sum = {1'b0, r_rem} + RSUM_W'(R_STEP);
        w_q_diff = (r_q > Q_W'(256)) ? (r_q - Q_W'(256)) : (Q_W'(256) - r_q);
        w_blue_diff = (r_q >= Q_W'(128)) ? (r_q - Q_W'(128)) : (Q_W'(128) - r_q);
        w_quot = r_prod[PROD_W-1:DIV_K];
        w_red_full = r_neg ? (PM_W'(0) - w_quot) : w_quot;
    end

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_cr        = r_cr;
        n_ci        = r_ci;
        n_limit     = r_limit;
        n_count     = r_count;
        n_q         = r_q;
        n_rem       = r_rem;
        n_esc       = r_esc;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_blue      = r_blue;
        n_prod      = r_prod;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_job_pop   = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            efp_pkg::ENG_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_a       = i_job.z_re;
                    n_b       = i_job.z_im;
                    n_cr      = i_job.c_re;
                    n_ci      = i_job.c_im;
                    n_limit   = i_job.limit;
                    n_count   = '0;
                    n_q       = '0;
                    n_rem     = '0;
                    n_state   = efp_pkg::ENG_ITER;
                end
            end
            efp_pkg::ENG_ITER: begin
                if (w_at_limit || (w_mag >= efp_pkg::ESCAPE_BOUND)) begin
                    // Set up the palette: red needs 2*(256-q)/3 truncated toward zero.
                    n_esc   = !w_at_limit;
                    n_neg   = (r_q > Q_W'(256));
                    n_mag   = {w_q_diff, 1'b0};
                    n_blue  = {w_blue_diff[COLOUR_W-2:0], 1'b0};
                    n_state = efp_pkg::ENG_DIV;
                end else begin
                    n_a     = w_re_sum[Z_W-1:0];
                    n_b     = w_im_sum[Z_W-1:0];
                    n_count = r_count + 1'b1;
                    // Keep q = count*256/steps by quotient and remainder steps.
                    if (w_rem_sum >= RSUM_W'(PALETTE_STEPS)) begin
                        n_rem = REM_W'(w_rem_sum - RSUM_W'(PALETTE_STEPS));
                        n_q   = r_q + Q_W'(Q_STEP) + 1'b1;
                    end else begin
                        n_rem = w_rem_sum[REM_W-1:0];
                        n_q   = r_q + Q_W'(Q_STEP);
                    end
                end
            end
            efp_pkg::ENG_DIV: begin
                n_prod  = PROD_W'(r_mag) * DIV_M;
                n_state = efp_pkg::ENG_DONE;
            end
            efp_pkg::ENG_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid           = 1'b1;
                    n_out.iteration_count = r_count;
                    n_out.escaped         = r_esc;
                    n_out.red             = r_esc ? w_red_full[COLOUR_W-1:0] : '0;
                    n_out.blue            = r_esc ? r_blue : '0;
                    n_state               = efp_pkg::ENG_IDLE;
                end
            end
            default: begin
                n_state = efp_pkg::ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= efp_pkg::ENG_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_cr    <= n_cr;
        r_ci    <= n_ci;
        r_limit <= n_limit;
        r_count <= n_count;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_esc   <= n_esc;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_blue  <= n_blue;
        r_prod  <= n_prod;
        r_out   <= n_out;
    end

endmodule

// File: bench/fractal_pixel_checker.sv
// Checker for the fractal pixel engine: tracks the registers, predicts every pixel and compares.
module fractal_pixel_checker #(
    parameter int MAX_ITERATIONS = efp_pkg::MAX_ITERATIONS_DEF,
    parameter int PALETTE_STEPS  = efp_pkg::PALETTE_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  efp_pkg::t_pixel_in              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  efp_pkg::t_pixel_out             i_out_data,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [efp_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [efp_pkg::COORD_W-1:0]     i_cfg_data,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import efp_pkg::*;

    localparam int REPORT_LINES = 50;

    typedef struct {
        t_pixel_in  point;
        t_pixel_out pixel;
    } t_pixel_due;

    t_pixel_due                 pixels_due[$];
    logic [CNT_W-1:0]           limit_reg;
    logic signed [COORD_W-1:0]  julia_re_reg;
    logic signed [COORD_W-1:0]  julia_im_reg;
    int                         mismatch_total = 0;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Iterates z = z^2 + c on the current register copy and derives the palette bytes.
    function automatic t_pixel_out escape_pixel(input t_pixel_in point);
        longint     z_re;
        longint     z_im;
        longint     c_re;
        longint     c_im;
        longint     next_re;
        int         lim;
        int         n;
        int         shade;
        int         red_val;
        int         spread;
        t_pixel_out pixel;
        lim = (limit_reg > MAX_ITERATIONS) ? MAX_ITERATIONS : int'(limit_reg);
        if (point.mode == MODE_CONST_C) begin
            z_re = longint'(point.point_re);
            z_im = longint'(point.point_im);
            c_re = longint'(julia_re_reg);
            c_im = longint'(julia_im_reg);
        end else begin
            z_re = 0;
            z_im = 0;
            c_re = longint'(point.point_re);
            c_im = longint'(point.point_im);
        end
        n = 0;
        while (n < lim && (z_re * z_re + z_im * z_im) < longint'(ESCAPE_BOUND)) begin
            next_re = ((z_re * z_re) >>> FRAC_RE) - ((z_im * z_im) >>> FRAC_RE) + c_re;
            z_im    = ((z_re * z_im) >>> FRAC_IM) + c_im;
            z_re    = next_re;
            n++;
        end
        pixel = '0;
        pixel.iteration_count = n[CNT_W-1:0];
        pixel.escaped = (n < lim);
        if (n < lim) begin
            shade = (n * 256) / PALETTE_STEPS;
            // Division truncates towards zero, so a negative red keeps its low byte as is.
            red_val = ((256 - shade) * 2) / 3;
            spread = shade - 128;
            if (spread < 0) begin
                spread = -spread;
            end
            pixel.red  = red_val[COLOUR_W-1:0];
            pixel.blue = 8'(spread * 2);
        end
        return pixel;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        if (mismatch_total <= REPORT_LINES) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got, input t_pixel_in point);
        if (want !== got) begin
            report_mismatch($sformatf("mode %0d point (%0d, %0d): %s expected %0d, got %0d",
                                      point.mode, point.point_re, point.point_im,
                                      field, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_due due;
        t_pixel_out got;
        if (!i_rst_n) begin
            limit_reg    = CNT_W'(LIMIT_RESET);
            julia_re_reg = '0;
            julia_im_reg = '0;
            pixels_due.delete();
        end else begin
            // Results are retired before new points are queued, so a result can never be
            // matched with the point accepted at the same edge.
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (pixels_due.size() == 0) begin
                    report_mismatch($sformatf("result with no point outstanding, count %0d",
                                              got.iteration_count));
                end else begin
                    due = pixels_due.pop_front();
                    check_field("iteration_count", 16'(due.pixel.iteration_count),
                                16'(got.iteration_count), due.point);
                    check_field("escaped", 16'(due.pixel.escaped), 16'(got.escaped), due.point);
                    check_field("red", 16'(due.pixel.red), 16'(got.red), due.point);
                    check_field("blue", 16'(due.pixel.blue), 16'(got.blue), due.point);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LIMIT:    limit_reg    = i_cfg_data[CNT_W-1:0];
                    CFG_JULIA_RE: julia_re_reg = i_cfg_data;
                    CFG_JULIA_IM: julia_im_reg = i_cfg_data;
                    default:      ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                due.point = i_in_data;
                due.pixel = escape_pixel(i_in_data);
                pixels_due.push_back(due);
            end
        end
        o_mismatches  <= mismatch_total;
        o_outstanding <= pixels_due.size();
    end

endmodule

// File: bench/testbench.sv
// Bench top for the fractal pixel engine: clock, reset, stimulus phases, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import efp_pkg::*;

    // The slowest legitimate gap between transfers is one point running to the clamped limit
    // of 2000 iterations plus its setup, so this leaves a wide margin.
    localparam int WATCHDOG_CYCLES = 10000;
    // Once nothing is outstanding, a short quiet spell shows up any stray extra result.
    localparam int SETTLE_CYCLES   = 64;
    localparam int PHASE_COUNT     = 12;
    localparam int DIRECTED_COUNT  = 19;
    // Index 3 has no register behind it; a write there must leave everything unchanged.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_pixel_in              in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_pixel_out             out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [COORD_W-1:0]     cfg_data  = '0;

    int mismatches;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int points_sent    = 0;
    int quiet_cycles   = 0;

    t_pixel_in directed_points [DIRECTED_COUNT];

    escape_time_fractal_pixel dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    fractal_pixel_checker pixel_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiving side decides afresh at every edge whether it will take a transfer, so
    // stalls land on every phase of the engine's work, including while a result is waiting.
    initial begin
        forever begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // The watchdog counts edges at which nothing moves on any channel. A hung handshake or a
    // result that never arrives ends the run here rather than letting it spin for ever.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                     WATCHDOG_CYCLES, outstanding);
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one point after a random number of idle cycles and holds it, unchanged, until
    // the engine takes the transfer. It returns at the edge of that transfer with valid still
    // high, so back-to-back points never lower and raise valid within one step.
    task automatic send_point(input t_pixel_in point);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= point;
        do @(posedge clk); while (!in_ready);
        points_sent++;
    endtask

    // Writes one register and returns at the edge of the transfer. Valid stays high so that
    // several writes can follow one another; the caller lowers it after the last.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [COORD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Stops offering points and waits until every expected result has arrived. The first edge
    // lets the checker count a point accepted at the edge on which this task was entered.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        int          phase;
        int          item;
        int          items_in_phase;
        int          pick;
        int          re_val;
        int          im_val;
        logic [15:0] lim_word;
        t_pixel_in   point;

        // The directed points run with the reset settings: a limit of 40 and a Julia constant
        // of zero. They cover the corners of the coordinate range, alternating bit patterns,
        // a magnitude landing exactly on the escape bound (which counts as escaped), slow
        // escapes whose count exceeds the palette range so that red goes negative before its
        // low byte is taken, points inside the set that run to the limit, and negative
        // products that exercise the flooring shifts.
        directed_points = '{
            '{MODE_MANDELBROT, 16'sd0,      16'sd0},
            '{MODE_MANDELBROT, 16'h8000,    16'h8000},
            '{MODE_MANDELBROT, 16'h7FFF,    16'h7FFF},
            '{MODE_MANDELBROT, 16'h8000,    16'h7FFF},
            '{MODE_MANDELBROT, 16'h5555,    16'hAAAA},
            '{MODE_MANDELBROT, -16'sd16384, 16'sd0},
            '{MODE_MANDELBROT, 16'sd2130,   16'sd0},
            '{MODE_MANDELBROT, 16'sd2212,   16'sd0},
            '{MODE_MANDELBROT, -16'sd6144,  16'sd819},
            '{MODE_MANDELBROT, -16'sd10240, 16'sd0},
            '{MODE_MANDELBROT, -16'sd3000,  -16'sd5000},
            '{MODE_MANDELBROT, 16'sd2048,   16'sd4096},
            '{MODE_CONST_C,    16'sd0,      16'sd0},
            '{MODE_CONST_C,    16'h7FFF,    16'h8000},
            '{MODE_CONST_C,    16'hAAAA,    16'h5555},
            '{MODE_CONST_C,    16'sd4096,   -16'sd4096},
            '{MODE_CONST_C,    16'sd8192,   16'sd0},
            '{MODE_CONST_C,    16'sd8200,   16'sd0},
            '{MODE_CONST_C,    16'sd16384,  16'sd0}
        };

        // Synchronous reset, held from the start and never asserted again.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            // Idling cycles through four patterns: none, a sparse sender, a slow receiver,
            // and both sides idling about a third of the time.
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase

            // Registers are only written here, once the previous phase has fully drained.
            // The early phases take the extremes: a limit of zero, a limit above the maximum
            // (upper data bits set as well), exactly the maximum, and a limit of one.
            case (phase)
                0: ;
                1: begin
                    write_reg(CFG_LIMIT, 16'h0000);
                    write_reg(CFG_JULIA_RE, 16'h8000);
                    write_reg(CFG_SPARE, 16'hFFFF);
                    write_reg(CFG_JULIA_IM, 16'h7FFF);
                end
                2: begin
                    write_reg(CFG_LIMIT, 16'hFFFF);
                    write_reg(CFG_JULIA_RE, 16'h7FFF);
                    write_reg(CFG_JULIA_IM, 16'h8000);
                end
                3: begin
                    write_reg(CFG_LIMIT, 16'(MAX_ITERATIONS_DEF));
                    write_reg(CFG_JULIA_RE, -16'sd6554);
                    write_reg(CFG_JULIA_IM, 16'sd1278);
                end
                default: begin
                    lim_word = (phase == 4) ? 16'd1 : 16'($urandom_range(300, 2));
                    // Bits above the limit field are ignored by the register; set some anyway.
                    lim_word[15:CNT_W] = 5'($urandom);
                    re_val = int'($urandom_range(16384)) - 8192;
                    im_val = int'($urandom_range(16384)) - 8192;
                    write_reg(CFG_LIMIT, lim_word);
                    write_reg(CFG_JULIA_RE, re_val[15:0]);
                    write_reg(CFG_JULIA_IM, im_val[15:0]);
                end
            endcase
            cfg_valid <= 1'b0;

            if (phase == 0) begin
                for (item = 0; item < DIRECTED_COUNT; item++) begin
                    send_point(directed_points[item]);
                end
            end

            // Phases with a limit at or above the maximum are kept very short, since a point
            // inside the set holds the engine until it reaches the full limit.
            if (phase == 2 || phase == 3) begin
                items_in_phase = 6;
            end else if (phase == 0) begin
                items_in_phase = 200;
            end else if (phase == 1 || phase == 4) begin
                items_in_phase = 100;
            end else begin
                items_in_phase = 180;
            end

            for (item = 0; item < items_in_phase; item++) begin
                // A quarter of the points span the whole coordinate range so every bit
                // toggles; most of those escape at once. The rest are drawn from the region
                // where the sets live, which gives long runs, slow escapes and the full
                // spread of counts and palette values.
                pick = $urandom_range(99);
                point.mode = ($urandom_range(1) == 1) ? MODE_CONST_C : MODE_MANDELBROT;
                if (pick < 25) begin
                    re_val = $urandom;
                    im_val = $urandom;
                end else if (point.mode == MODE_MANDELBROT) begin
                    re_val = int'($urandom_range(26214)) - 18022;
                    im_val = int'($urandom_range(24576)) - 12288;
                end else begin
                    re_val = int'($urandom_range(29492)) - 14746;
                    im_val = int'($urandom_range(29492)) - 14746;
                end
                point.point_re = re_val[15:0];
                point.point_im = im_val[15:0];
                send_point(point);
                // Once in the run the sender holds off mid-phase until the engine is empty,
                // so the queue and the engine restart from cold with the same settings.
                if (phase == 6 && item == items_in_phase / 2) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d points under %0d register settings, both modes, limits from zero",
                 points_sent, PHASE_COUNT);
        $display("to above the maximum, escape-bound corners and four patterns of idling.");
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
